FILE: hw/rtl/btipf_pkg.sv
// Package for the BER-TLV image payload finder.
// Holds the request and result types, parse phases, outcome codes and tag/signature constants.
// No dependencies.
`default_nettype none

package btipf_pkg;

    // Default width of blob positions and lengths
    localparam int DEFAULT_LENGTH_BITS = 24;
    // Width of a decoded TLV value length (up to three length bytes)
    localparam int VLEN_BITS           = 24;
    localparam int WIN_BITS            = 48;

    // Request kinds
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // Tags of the biometric data block
    localparam logic [15:0] TAG_IMAGE_A = 16'h5F2E;
    localparam logic [15:0] TAG_IMAGE_B = 16'h7F2E;
    localparam logic [4:0]  TAG_NUMBER_ESCAPE = 5'h1F;
    localparam int          TAG_CONSTRUCTED_BIT = 5;

    // Long-form length prefixes
    localparam logic [7:0] LEN_LONG_1 = 8'h81;
    localparam logic [7:0] LEN_LONG_3 = 8'h83;

    // Image signatures
    localparam logic [23:0] SIG_JPEG_SOI = 24'hFF_D8_FF;
    localparam logic [47:0] SIG_JP2_BOX  = 48'h00_00_00_0C_6A_50;
    localparam logic [31:0] SIG_J2C_SOC  = 32'hFF_4F_FF_51;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG1,
        PH_TAG2,
        PH_LEN,
        PH_LENX,
        PH_SKIP,
        PH_SCAN,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        OUT_NONE  = 3'd0,
        OUT_JPEG  = 3'd1,
        OUT_JP2   = 3'd2,
        OUT_J2C   = 3'd3,
        OUT_WHOLE = 3'd4
    } outcome_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  data_byte;
        logic [23:0] blob_length;
    } req_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [23:0] image_offset;
        logic [23:0] image_length;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/btipf_in_stage.sv
// Input register stage of the BER-TLV image payload finder.
// Captures one request and holds it until the walker consumes it; uses btipf_pkg.
`default_nettype none

module btipf_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire btipf_pkg::req_t in_req,
    input  wire logic            advance,
    output logic                 item_valid,
    output btipf_pkg::req_t      item
);

    logic            valid_reg;
    logic            valid_next;
    btipf_pkg::req_t req_reg;
    logic            load;

    // Free when empty or when the held request moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = req_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= in_req;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/btipf_out_stage.sv
// Result register stage of the BER-TLV image payload finder.
// Holds one result until the consumer takes it; uses btipf_pkg.
`default_nettype none

module btipf_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire btipf_pkg::result_t push_result,
    output logic                    blocked,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output btipf_pkg::result_t      out_result
);

    logic               valid_reg;
    logic               valid_next;
    btipf_pkg::result_t result_reg;

    // A waiting result that is not taken this cycle blocks a new one
    assign blocked    = valid_reg && !out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            result_reg <= push_result;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/btipf_walker.sv
// TLV walker of the BER-TLV image payload finder: parse state and per-byte update.
// Decodes headers, skips or enters values and scans the image value; uses btipf_pkg.
`default_nettype none

module btipf_walker #(
    parameter int LENGTH_BITS = btipf_pkg::DEFAULT_LENGTH_BITS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire btipf_pkg::req_t item,
    input  wire logic            out_blocked,
    output logic                 advance,
    output logic                 push,
    output btipf_pkg::result_t   result
);

    localparam int SUM_W = ((LENGTH_BITS > btipf_pkg::VLEN_BITS) ?
                            LENGTH_BITS : btipf_pkg::VLEN_BITS) + 2;

    // Control state
    btipf_pkg::phase_t   phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic [1:0]             left_reg, left_next;
    btipf_pkg::outcome_t    dec_out_reg, dec_out_next;

    // Working values
    logic [15:0]            tag_reg, tag_next;
    logic [23:0]            acc_reg, acc_next;
    logic [SUM_W-1:0]       skip_end_reg, skip_end_next;
    logic [LENGTH_BITS-1:0] pstart_reg, pstart_next;
    logic [SUM_W-1:0]       pend_reg, pend_next;
    logic [47:0]            win_reg, win_next;
    logic [LENGTH_BITS-1:0] dec_off_reg, dec_off_next;

    logic [7:0]       b;
    logic [SUM_W-1:0] p_ext, p1, p2, total_ext, pstart_ext;
    logic             is_start, walking, emit;
    logic [23:0]      acc_shift;
    logic [1:0]       left_dec;
    logic [47:0]      win_shift;
    logic             hdr_go;
    logic [23:0]      hdr_vlen;
    logic [SUM_W-1:0] hdr_end;
    logic [7:0]       first_tag_byte;
    logic             tag_matched;

    // Position arithmetic
    assign b          = item.data_byte;
    assign p_ext      = SUM_W'(pos_reg);
    assign p1         = p_ext + SUM_W'(1);
    assign p2         = p_ext + SUM_W'(2);
    assign total_ext  = SUM_W'(total_reg);
    assign pstart_ext = SUM_W'(pstart_reg);

    assign is_start = (item.mode == btipf_pkg::MODE_START);
    assign walking  = !is_start && (phase_reg != btipf_pkg::PH_IDLE) && (p_ext < total_ext);
    assign emit     = item_valid && walking && (p1 == total_ext);

    // Stall only a request that would produce a result into a full output
    assign advance = item_valid && !(emit && out_blocked);
    assign push    = advance && emit;

    // Header completion: value length known on this byte
    assign acc_shift = {acc_reg[15:0], b};
    assign left_dec  = left_reg - 2'd1;

    always_comb
    begin
        hdr_go   = 1'b0;
        hdr_vlen = acc_shift;
        if (phase_reg == btipf_pkg::PH_LEN && !b[7])
        begin
            hdr_go   = 1'b1;
            hdr_vlen = {16'd0, b};
        end
        else if (phase_reg == btipf_pkg::PH_LENX && left_dec == 2'd0)
        begin
            hdr_go = 1'b1;
        end
    end

    assign hdr_end        = p1 + SUM_W'(hdr_vlen);
    assign first_tag_byte = (tag_reg[15:8] != 8'd0) ? tag_reg[15:8] : tag_reg[7:0];
    assign tag_matched    = (tag_reg == btipf_pkg::TAG_IMAGE_A) ||
                            (tag_reg == btipf_pkg::TAG_IMAGE_B);
    assign win_shift      = {win_reg[39:0], b};

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        left_next     = left_reg;
        dec_out_next  = dec_out_reg;
        tag_next      = tag_reg;
        acc_next      = acc_reg;
        skip_end_next = skip_end_reg;
        pstart_next   = pstart_reg;
        pend_next     = pend_reg;
        win_next      = win_reg;
        dec_off_next  = dec_off_reg;

        if (advance && is_start)
        begin
            // New blob: drop whatever walk was under way
            total_next   = LENGTH_BITS'(item.blob_length);
            pos_next     = '0;
            dec_out_next = btipf_pkg::OUT_NONE;
            dec_off_next = '0;
            phase_next   = (total_next != '0) ? btipf_pkg::PH_TAG1 : btipf_pkg::PH_IDLE;
        end
        else if (advance && walking)
        begin
            pos_next = LENGTH_BITS'(p1);
            unique case (phase_reg)
                btipf_pkg::PH_TAG1:
                begin
                    // Header must leave room for tag and length
                    if (p2 >= total_ext)
                    begin
                        dec_out_next = btipf_pkg::OUT_NONE;
                        dec_off_next = '0;
                        phase_next   = btipf_pkg::PH_DONE;
                    end
                    else
                    begin
                        tag_next   = {8'd0, b};
                        phase_next = (b[4:0] == btipf_pkg::TAG_NUMBER_ESCAPE) ?
                                     btipf_pkg::PH_TAG2 : btipf_pkg::PH_LEN;
                    end
                end
                btipf_pkg::PH_TAG2:
                begin
                    tag_next   = {tag_reg[7:0], b};
                    phase_next = btipf_pkg::PH_LEN;
                end
                btipf_pkg::PH_LEN:
                begin
                    if (b >= btipf_pkg::LEN_LONG_1 && b <= btipf_pkg::LEN_LONG_3)
                    begin
                        acc_next   = '0;
                        left_next  = b[1:0];
                        phase_next = btipf_pkg::PH_LENX;
                    end
                    else if (b[7])
                    begin
                        // Indefinite or over-long length form
                        dec_out_next = btipf_pkg::OUT_NONE;
                        dec_off_next = '0;
                        phase_next   = btipf_pkg::PH_DONE;
                    end
                end
                btipf_pkg::PH_LENX:
                begin
                    acc_next  = acc_shift;
                    left_next = left_dec;
                end
                btipf_pkg::PH_SKIP:
                begin
                    if (p1 >= skip_end_reg)
                    begin
                        phase_next = btipf_pkg::PH_TAG1;
                    end
                end
                btipf_pkg::PH_SCAN:
                begin
                    win_next = win_shift;
                    priority if (p_ext >= pstart_ext + SUM_W'(2) &&
                                 win_shift[23:0] == btipf_pkg::SIG_JPEG_SOI &&
                                 p1 < pend_reg)
                    begin
                        dec_out_next = btipf_pkg::OUT_JPEG;
                        dec_off_next = LENGTH_BITS'(p_ext - SUM_W'(2));
                        phase_next   = btipf_pkg::PH_DONE;
                    end
                    else if (p_ext >= pstart_ext + SUM_W'(5) &&
                             win_shift == btipf_pkg::SIG_JP2_BOX &&
                             p2 < pend_reg)
                    begin
                        dec_out_next = btipf_pkg::OUT_JP2;
                        dec_off_next = LENGTH_BITS'(p_ext - SUM_W'(5));
                        phase_next   = btipf_pkg::PH_DONE;
                    end
                    else if (p_ext >= pstart_ext + SUM_W'(3) &&
                             win_shift[31:0] == btipf_pkg::SIG_J2C_SOC)
                    begin
                        dec_out_next = btipf_pkg::OUT_J2C;
                        dec_off_next = LENGTH_BITS'(p_ext - SUM_W'(3));
                        phase_next   = btipf_pkg::PH_DONE;
                    end
                    else if (p1 >= pend_reg)
                    begin
                        // No signature: take the whole value
                        dec_out_next = btipf_pkg::OUT_WHOLE;
                        dec_off_next = pstart_reg;
                        phase_next   = btipf_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = btipf_pkg::PH_SCAN;
                    end
                end
                btipf_pkg::PH_IDLE,
                btipf_pkg::PH_DONE:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // Complete header: check bounds, then enter, skip or scan the value
            if (hdr_go)
            begin
                if (hdr_end > total_ext)
                begin
                    dec_out_next = btipf_pkg::OUT_NONE;
                    dec_off_next = '0;
                    phase_next   = btipf_pkg::PH_DONE;
                end
                else if (tag_matched)
                begin
                    pstart_next = LENGTH_BITS'(p1);
                    pend_next   = hdr_end;
                    win_next    = '0;
                    if (hdr_vlen == 24'd0)
                    begin
                        dec_out_next = btipf_pkg::OUT_WHOLE;
                        dec_off_next = LENGTH_BITS'(p1);
                        phase_next   = btipf_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = btipf_pkg::PH_SCAN;
                    end
                end
                else if (first_tag_byte[btipf_pkg::TAG_CONSTRUCTED_BIT] || hdr_vlen == 24'd0)
                begin
                    phase_next = btipf_pkg::PH_TAG1;
                end
                else
                begin
                    skip_end_next = hdr_end;
                    phase_next    = btipf_pkg::PH_SKIP;
                end
            end

            // Final byte of the blob closes it
            if (p1 == total_ext)
            begin
                phase_next = btipf_pkg::PH_IDLE;
            end
        end
    end

    // Result for the final byte
    always_comb
    begin
        if (dec_out_next != btipf_pkg::OUT_NONE)
        begin
            result.outcome      = dec_out_next;
            result.image_offset = 24'(dec_off_next);
            result.image_length = 24'(pend_next - SUM_W'(dec_off_next));
        end
        else
        begin
            result.outcome      = btipf_pkg::OUT_NONE;
            result.image_offset = 24'd0;
            result.image_length = 24'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= btipf_pkg::PH_IDLE;
            pos_reg     <= '0;
            total_reg   <= '0;
            left_reg    <= '0;
            dec_out_reg <= btipf_pkg::OUT_NONE;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            left_reg    <= left_next;
            dec_out_reg <= dec_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        acc_reg      <= acc_next;
        skip_end_reg <= skip_end_next;
        pstart_reg   <= pstart_next;
        pend_reg     <= pend_next;
        win_reg      <= win_next;
        dec_off_reg  <= dec_off_next;
    end

    // Checks
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> phase_reg == btipf_pkg::PH_IDLE)
        else $error("walker not idle after final byte");

    a_pos_in_blob: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != btipf_pkg::PH_IDLE |-> pos_reg < total_reg)
        else $error("byte position past blob end while walking");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (push && result.outcome == btipf_pkg::OUT_NONE) |->
        (result.image_offset == 24'd0 && result.image_length == 24'd0))
        else $error("not-found result carries offset or length");

    a_no_push_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_blocked |-> !push)
        else $error("result pushed into a full output register");

endmodule

`default_nettype wire

FILE: hw/rtl/ber_tlv_image_payload_finder_unit.sv
// Top level of the BER-TLV image payload finder.
// Instantiates btipf_in_stage, btipf_walker and btipf_out_stage; uses btipf_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | request   | in_valid/in_ready  | mode, data_byte, blob_length
//   out     | result    | out_valid/out_ready| outcome, image_offset, image_length
//
// One request per cycle sustained while no final byte stalls; a final byte is held in the input register,
// the walker forms its result combinationally, and the output register then holds that result.
// rst_n clears the parse phase, position, blob length and both stage valids.
// A final byte stalls only while an untaken result sits in the output register;
// other requests keep flowing while the result waits.
`default_nettype none

module ber_tlv_image_payload_finder_unit #(
    parameter int LENGTH_BITS = btipf_pkg::DEFAULT_LENGTH_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic [23:0] blob_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       outcome,
    output logic [23:0]      image_offset,
    output logic [23:0]      image_length
);

    btipf_pkg::req_t    in_req;
    btipf_pkg::req_t    item;
    logic               item_valid;
    logic               advance;
    logic               push;
    logic               out_blocked;
    btipf_pkg::result_t push_result;
    btipf_pkg::result_t out_result;

    assign in_req.mode        = mode;
    assign in_req.data_byte   = data_byte;
    assign in_req.blob_length = blob_length;

    btipf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_req     (in_req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    btipf_walker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .out_blocked (out_blocked),
        .advance     (advance),
        .push        (push),
        .result      (push_result)
    );

    btipf_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_result (push_result),
        .blocked     (out_blocked),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign outcome      = out_result.outcome;
    assign image_offset = out_result.image_offset;
    assign image_length = out_result.image_length;

endmodule

`default_nettype wire
